@@ design/tick_task_scheduler_unit_defines.svh @@
// Assertion macros for the scheduler checker
`ifndef TICK_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define TICK_TASK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication
`define TTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

@@ design/tts_pkg.sv @@
// Types and constants of the tick task scheduler
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_PAUSE   = 3'd2;
  localparam logic [2:0] OP_RESTART = 3'd3;
  localparam logic [2:0] OP_MODIFY  = 3'd4;
  localparam logic [2:0] OP_REMOVE  = 3'd5;
  localparam logic [2:0] OP_QUERY   = 3'd6;
  localparam logic [2:0] OP_DONE    = 3'd7;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_DISP  = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  localparam logic [1:0] MODE_PAUSED   = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_ONCE     = 2'd2;

  localparam logic [2:0] ST_MODE_MASK  = 3'b011;
  localparam logic [2:0] ST_IMMEDIATE  = 3'b100;
  localparam logic [2:0] ST_ADD_MAX    = 3'd5;

  localparam int          PERIOD_W     = 18;
  localparam logic [31:0] MAX_INTERVAL = 32'd225000;
  localparam logic [3:0]  MAX_RESULTS  = 4'd8;

  typedef struct packed {
    logic [7:0]          id;
    logic [1:0]          mode;
    logic [PERIOD_W-1:0] period;
    logic [31:0]         due;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] task_ref;
    logic       fail;
    logic [1:0] task_mode;
    logic       found;
    logic       last;
  } result_t;

  function automatic logic [PERIOD_W-1:0] fix_interval(input logic [31:0] v);
    logic [PERIOD_W-1:0] r;
    if (v == 32'd0 || v > MAX_INTERVAL) r = PERIOD_W'(1);
    else r = v[PERIOD_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/tts_if.sv @@
// Command and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  task_id;
  logic [31:0] interval;
  logic [2:0]  status;
  modport source (output valid, op, task_id, interval, status, input ready);
  modport sink (input valid, op, task_id, interval, status, output ready);
endinterface

interface tts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] task_ref;
  logic       fail;
  logic [1:0] task_mode;
  logic       found;
  logic       last;
  modport source (output valid, kind, task_ref, fail, task_mode, found, last,
                  input ready);
  modport sink (input valid, kind, task_ref, fail, task_mode, found, last,
                output ready);
  modport mon (input valid, ready, kind, task_ref, fail, task_mode, found, last);
endinterface
`default_nettype wire

@@ design/tts_cell.sv @@
// One table cell: holds an entry, takes its neighbour's or a loaded one
`timescale 1ns / 1ps
`default_nettype none
module tts_cell (
  input  wire logic              clk,
  input  wire tts_pkg::cell_ctl_t ctl,
  input  wire tts_pkg::entry_t   right,
  input  wire tts_pkg::entry_t   load_val,
  output tts_pkg::entry_t        ent
);
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent <= load_val;
    end else if (ctl.shift) begin
      ent <= right;
    end
  end
endmodule
`default_nettype wire

@@ design/tick_task_scheduler_unit.sv @@
// Tick task scheduler top level: controller over a row of table cells
// Usage:
//  cmd_in carries one command word (op, task_id, interval, status); res_out
//  carries result words (kind, task_ref, fail, task_mode, found, last).
//  cfg_we/cfg_wdata write the freeze timeout; the user must write it
//  only while idle, as the block does not enforce this. After a command
//  is taken the table rotates through cell 0 once, except for add, task
//  done and busy ticks. Unless a res_out stall holds the rotation, one
//  head entry a cycle is examined, updated, dropped or sent to the tail.
//  A tick's dispatch words go out as they are found; the last one of an
//  item carries last. An idle tick gives no word.
//  A result register parts the sides: the next command is taken while a
//  word still waits. When res_out stalls and a second word is ready the
//  rotation holds in place.
//  Reset (rst, synchronous) empties the table, clears the tick counter,
//  busy flag, freeze count and timeout; table cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module tick_task_scheduler_unit #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tts_in_if.sink           cmd_in,
  tts_out_if.source        res_out,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;

  logic [2:0]  cmd_op;
  logic [7:0]  cmd_id;
  logic [31:0] cmd_iv;
  logic [2:0]  cmd_st;

  logic [31:0]   tick_count;
  logic [CW-1:0] entry_count;
  logic          busy_flag;
  logic [15:0]   freeze_left;
  logic [15:0]   freeze_to;
  logic [CW-1:0] left_cnt;
  logic [3:0]    disp_cnt;
  logic          matched;
  logic [1:0]    qmode;
  logic          pv;
  tts_pkg::result_t pend;
  logic          ov;
  tts_pkg::result_t od;

  tts_pkg::entry_t   ent [TABLE_DEPTH];
  tts_pkg::cell_ctl_t cctl [TABLE_DEPTH];
  tts_pkg::entry_t   load_val;
  tts_pkg::entry_t   head;
  tts_pkg::entry_t   hp;
  tts_pkg::entry_t   new_ent;

  logic        accept, slot_free, is_tick, is_lookup, scanning;
  logic        dispatch, stall, step_go, drop, hit, add_go, table_full;
  logic [31:0] diff;
  logic [2:0]  add_st;
  logic [tts_pkg::PERIOD_W-1:0] in_fix, cmd_fix;
  logic [15:0] fl_dec;
  tts_pkg::result_t fin_res, disp_res;
  logic        fin_valid;
  logic        ov_set;

  assign cmd_in.ready = (state == ST_IDLE);
  assign accept       = cmd_in.valid && cmd_in.ready;
  assign slot_free    = !ov || res_out.ready;
  assign head         = ent[0];
  assign is_tick      = (cmd_op == tts_pkg::OP_TICK);
  assign is_lookup    = !is_tick && cmd_op != tts_pkg::OP_ADD && cmd_op != tts_pkg::OP_DONE;
  assign scanning     = (state == ST_SCAN) && (left_cnt != '0);
  assign diff         = tick_count - head.due;
  assign hit          = is_lookup && !matched && head.id == cmd_id;
  assign dispatch     = is_tick && disp_cnt < tts_pkg::MAX_RESULTS &&
                        head.mode != tts_pkg::MODE_PAUSED && !diff[31];
  assign stall        = dispatch && pv && !slot_free;
  assign step_go      = scanning && !stall;
  assign drop         = (dispatch && head.mode == tts_pkg::MODE_ONCE) ||
                        (hit && cmd_op == tts_pkg::OP_REMOVE);
  assign table_full   = (entry_count >= CW'(TABLE_DEPTH));
  assign add_go       = accept && cmd_in.op == tts_pkg::OP_ADD && !table_full;
  assign cmd_fix      = tts_pkg::fix_interval(cmd_iv);
  assign in_fix       = tts_pkg::fix_interval(cmd_in.interval);
  assign add_st       = (cmd_in.status > tts_pkg::ST_ADD_MAX) ? 3'd1 : cmd_in.status;
  assign fl_dec       = (freeze_left == 16'd0) ? 16'd0 : freeze_left - 16'd1;
  // output register takes a word this cycle
  assign ov_set       = (step_go && dispatch && pv) ||
                        (state == ST_FIN && fin_valid && slot_free);

  // head entry as it goes back to the tail
  always_comb begin
    hp = head;
    if (dispatch) begin
      hp.due = tick_count + {14'd0, head.period};
    end else if (hit) begin
      case (cmd_op)
        tts_pkg::OP_PAUSE: hp.mode = tts_pkg::MODE_PAUSED;
        tts_pkg::OP_RESTART: begin
          hp.mode = tts_pkg::MODE_PERIODIC;
          hp.due  = tick_count + {14'd0, head.period};
        end
        tts_pkg::OP_MODIFY: begin
          hp.period = cmd_fix;
          if (cmd_st == 3'd1 || cmd_st == 3'd2) hp.mode = cmd_st[1:0];
          hp.due = tick_count + {14'd0, cmd_fix};
        end
        default: hp = head;
      endcase
    end
  end

  always_comb begin
    new_ent.id     = cmd_in.task_id;
    new_ent.mode   = add_st[1:0] & tts_pkg::ST_MODE_MASK[1:0];
    new_ent.period = in_fix;
    new_ent.due    = tick_count + (((add_st & tts_pkg::ST_IMMEDIATE) != 3'd0) ?
                                   32'd0 : {14'd0, in_fix});
  end

  assign load_val = add_go ? new_ent : hp;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      always_comb begin
        cctl[gi].shift = step_go && (CW'(gi + 1) < entry_count);
        cctl[gi].load  = (step_go && !drop && CW'(gi + 1) == entry_count) ||
                         (add_go && CW'(gi) == entry_count);
      end
      if (gi == TABLE_DEPTH - 1) begin : g_end
        tts_cell u_cell (.clk(clk), .ctl(cctl[gi]), .right(ent[gi]),
                         .load_val(load_val), .ent(ent[gi]));
      end else begin : g_mid
        tts_cell u_cell (.clk(clk), .ctl(cctl[gi]), .right(ent[gi + 1]),
                         .load_val(load_val), .ent(ent[gi]));
      end
    end
  endgenerate

  always_comb begin
    disp_res = '{kind: tts_pkg::KIND_DISP, task_ref: head.id, fail: 1'b0,
                 task_mode: 2'd0, found: 1'b0, last: 1'b0};
    if (is_lookup) begin
      fin_valid = 1'b1;
      fin_res   = '{kind: tts_pkg::KIND_REPLY, task_ref: cmd_id, fail: !matched,
                    task_mode: (cmd_op == tts_pkg::OP_QUERY && matched) ? qmode : 2'd0,
                    found: matched, last: 1'b1};
    end else begin
      fin_valid     = pv;
      fin_res       = pend;
      fin_res.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tick_count  <= '0;
      entry_count <= '0;
      busy_flag   <= 1'b0;
      freeze_left <= '0;
      freeze_to   <= '0;
      left_cnt    <= '0;
      disp_cnt    <= '0;
      matched     <= 1'b0;
      pv          <= 1'b0;
      ov          <= 1'b0;
    end else begin
      if (cfg_we) freeze_to <= cfg_wdata;
      if (ov_set) begin
        ov <= 1'b1;
      end else if (ov && res_out.ready) begin
        ov <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_op   <= cmd_in.op;
            cmd_id   <= cmd_in.task_id;
            cmd_iv   <= cmd_in.interval;
            cmd_st   <= cmd_in.status;
            disp_cnt <= '0;
            matched  <= 1'b0;
            state    <= ST_SCAN;
            case (cmd_in.op)
              tts_pkg::OP_TICK: begin
                tick_count <= tick_count + 32'd1;
                if (busy_flag && freeze_to != 16'd0) begin
                  freeze_left <= fl_dec;
                  if (fl_dec == 16'd0) begin
                    pv   <= 1'b1;
                    pend <= '{kind: tts_pkg::KIND_RESET, task_ref: 8'd0, fail: 1'b0,
                              task_mode: 2'd0, found: 1'b0, last: 1'b1};
                  end
                end else begin
                  left_cnt <= entry_count;
                end
              end
              tts_pkg::OP_ADD: begin
                pv   <= 1'b1;
                pend <= '{kind: tts_pkg::KIND_REPLY, task_ref: cmd_in.task_id,
                          fail: table_full, task_mode: 2'd0, found: 1'b0, last: 1'b1};
                if (!table_full) entry_count <= entry_count + CW'(1);
              end
              tts_pkg::OP_DONE: begin
                busy_flag <= 1'b0;
                pv   <= 1'b1;
                pend <= '{kind: tts_pkg::KIND_REPLY, task_ref: cmd_in.task_id,
                          fail: 1'b0, task_mode: 2'd0, found: 1'b0, last: 1'b1};
              end
              default: left_cnt <= entry_count;
            endcase
          end
        end
        ST_SCAN: begin
          if (left_cnt == '0) begin
            state <= ST_FIN;
          end else if (step_go) begin
            left_cnt <= left_cnt - CW'(1);
            if (drop) entry_count <= entry_count - CW'(1);
            if (hit) begin
              matched <= 1'b1;
              qmode   <= head.mode;
            end
            if (dispatch) begin
              if (pv) begin
                od <= pend;
              end
              pv          <= 1'b1;
              pend        <= disp_res;
              busy_flag   <= 1'b1;
              freeze_left <= freeze_to;
              disp_cnt    <= disp_cnt + 4'd1;
            end
          end
        end
        ST_FIN: begin
          if (!fin_valid) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            od    <= fin_res;
            pv    <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res_out.valid     = ov;
  assign res_out.kind      = od.kind;
  assign res_out.task_ref  = od.task_ref;
  assign res_out.fail      = od.fail;
  assign res_out.task_mode = od.task_mode;
  assign res_out.found     = od.found;
  assign res_out.last      = od.last;
endmodule
`default_nettype wire

@@ design/tts_checker.sv @@
// Port-level checks on the scheduler result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "tick_task_scheduler_unit_defines.svh"
module tts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [1:0] kind,
  input wire logic [7:0] task_ref,
  input wire logic       fail,
  input wire logic       found,
  input wire logic       last
);
  `TTS_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(task_ref) && $stable(kind) && $stable(last))
  `TTS_ASSERT_NOW(a_kind, valid, kind != 2'd3)
  `TTS_ASSERT_NOW(a_reply_last, valid && kind == tts_pkg::KIND_REPLY, last && !(fail && found))
  `TTS_ASSERT_NOW(a_reset_word, valid && kind == tts_pkg::KIND_RESET, last && task_ref == 8'd0 && !found && !fail)
endmodule

bind tick_task_scheduler_unit tts_checker u_tts_checker (
  .clk(clk),
  .rst(rst),
  .valid(res_out.valid),
  .ready(res_out.ready),
  .kind(res_out.kind),
  .task_ref(res_out.task_ref),
  .fail(res_out.fail),
  .found(res_out.found),
  .last(res_out.last)
);
`default_nettype wire
